[sv/assert_macros.svh]
// assertion macros included by the accumulator machine top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock, off while in reset
`define AVM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define AVM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/avm_pkg.sv]
// shared types and constants for the accumulator machine block
`default_nettype none
package avm_pkg;

    localparam int MEM_DEPTH = 256;
    localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int CW = $clog2(MEM_DEPTH + 1);

    typedef enum logic [4:0] {
        OP_CLEAR = 5'd0, OP_AT = 5'd1, OP_SET = 5'd2, OP_INSERT = 5'd3,
        OP_ERASE = 5'd4, OP_ADDC = 5'd5, OP_SUBC = 5'd6, OP_MULC = 5'd7,
        OP_DIVC = 5'd8, OP_ADDM = 5'd9, OP_SUBM = 5'd10, OP_MULM = 5'd11,
        OP_DIVM = 5'd12, OP_JREL = 5'd13, OP_JZ = 5'd14, OP_JNZ = 5'd15,
        OP_NOOP = 5'd16, OP_HALT = 5'd17, OP_OUT = 5'd18, OP_CHKMEM = 5'd19,
        OP_UNKNOWN = 5'd20, OP_PRELOAD = 5'd21
    } op_t;

    typedef enum logic [1:0] {
        ST_RUN = 2'd0, ST_HALT = 2'd1, ST_ERR = 2'd2, ST_UNK = 2'd3
    } run_t;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_RDW, S_SHIFT_RD, S_SHIFT_WR, S_MUL, S_DIV, S_DIVW, S_DONE
    } fsm_t;

    typedef struct packed {
        logic [4:0]         op;
        logic signed [63:0] argument;
    } in_t;

    typedef struct packed {
        logic signed [63:0] pc_step;
        logic [1:0]         run_status;
        logic               out_valid;
        logic signed [63:0] out_value;
    } out_t;

    // divider request and reply
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

[sv/avm_ram.sv]
// single port synchronous data memory with registered read data
`default_nettype none
module avm_ram #(
    parameter int DEPTH = 256,
    parameter int AWID = 8
) (
    input  wire logic            clk,
    input  wire logic            we,
    input  wire logic [AWID-1:0] addr,
    input  wire logic [63:0]     wdata,
    output logic [63:0]          rdata
);
    logic [63:0] mem [DEPTH];

    // read first port: a write returns the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

[sv/avm_div.sv]
// iterative signed divider, one quotient bit per cycle
`default_nettype none
module avm_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire avm_pkg::div_req_t req,
    output avm_pkg::div_rsp_t     rsp
);
    import avm_pkg::*;

    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] dvs_reg, dvs_next;
    logic        neg_reg, neg_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;

    // restoring division step over the magnitudes
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[63]} - {1'b0, dvs_reg};
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend[63] ? (64'd0 - req.dividend) : req.dividend;
            dvs_next  = req.divisor[63] ? (64'd0 - req.divisor) : req.divisor;
            neg_next  = req.dividend[63] ^ req.divisor[63];
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[64])
            begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[62:0], quo_reg[63]};
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (64'd0 - quo_reg) : quo_reg;
endmodule
`default_nettype wire

[sv/accumulator_vm_execute_top.sv]
// accumulator machine: sequencer around a data memory and a shared divider
// each instruction is decoded in S_RD, then memory operands are read in S_RDW, multiplies
// pass through S_MUL and S_DIV, divides wait in S_DIVW, and insert and erase move one word
// at a time through S_SHIFT_RD and S_SHIFT_WR, paced by the single memory port and divider.
// one instruction in flight; the next beat is taken only back in S_IDLE, after its result
// enters the output register, so a stalled result holds back one more finished instruction.
// reset clears acc, word count and status at once; memory needs no clearing.
`default_nettype none
`include "assert_macros.svh"
module accumulator_vm_execute_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire avm_pkg::in_t  in_data,
    output logic               res_valid,
    input  wire logic          res_stall,
    output avm_pkg::out_t      res_data
);
    import avm_pkg::*;

    fsm_t        state_reg, state_next;
    logic [4:0]  op_reg, op_next;
    logic [63:0] arg_reg, arg_next;
    logic [63:0] acc_reg, acc_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    run_t        st_reg, st_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [63:0] hold_reg, hold_next;
    logic [63:0] mul_reg, mul_next;
    logic        ov_reg, ov_next;
    out_t        out_reg, out_next;
    logic [63:0] step_reg, step_next;
    logic        emit_reg, emit_next;
    logic [63:0] val_reg, val_next;

    logic          we;
    logic [AW-1:0] addr;
    logic [63:0]   wdata, rdata;
    div_req_t      dreq;
    div_rsp_t      drsp;

    logic          arg_neg;
    logic          idx_ok;
    logic          ins_ok;
    logic [AW-1:0] arg_a;

    avm_ram #(.DEPTH(MEM_DEPTH), .AWID(AW)) u_ram (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    avm_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign in_stall  = (state_reg != S_IDLE);
    assign res_valid = ov_reg;
    assign res_data  = out_reg;

    assign arg_neg = arg_reg[63];
    assign idx_ok  = !arg_neg && (arg_reg < {{(64-CW){1'b0}}, cnt_reg});
    assign ins_ok  = !arg_neg && (arg_reg <= {{(64-CW){1'b0}}, cnt_reg})
                     && (cnt_reg < CW'(MEM_DEPTH));
    assign arg_a   = arg_reg[AW-1:0];

    // sequencer: decode, memory access, shift sweep and arithmetic
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        arg_next   = arg_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        st_next    = st_reg;
        ptr_next   = ptr_reg;
        hold_next  = hold_reg;
        mul_next   = mul_reg;
        ov_next    = ov_reg;
        out_next   = out_reg;
        step_next  = step_reg;
        emit_next  = emit_reg;
        val_next   = val_reg;
        we         = 1'b0;
        addr       = arg_a;
        wdata      = acc_reg;
        dreq       = '0;
        if (ov_reg && !res_stall)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    op_next    = in_data.op;
                    arg_next   = in_data.argument;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                // default result; overridden per op
                step_next  = 64'd1;
                emit_next  = 1'b0;
                val_next   = '0;
                state_next = S_DONE;
                if (st_reg != ST_RUN)
                begin
                    step_next = '0;
                end
                else
                begin
                    case (op_reg)
                        OP_CLEAR: acc_next = '0;
                        OP_AT, OP_ADDM, OP_SUBM, OP_MULM, OP_DIVM:
                        begin
                            if (idx_ok) state_next = S_RDW;
                            else        st_next = ST_ERR;
                        end
                        OP_SET:
                        begin
                            if (idx_ok) we = 1'b1;
                            else        st_next = ST_ERR;
                        end
                        OP_INSERT:
                        begin
                            if (ins_ok)
                            begin
                                ptr_next   = cnt_reg;
                                state_next = S_SHIFT_RD;
                            end
                            else st_next = ST_ERR;
                        end
                        OP_ERASE:
                        begin
                            if (idx_ok)
                            begin
                                ptr_next   = arg_reg[CW-1:0];
                                state_next = S_SHIFT_RD;
                            end
                            else st_next = ST_ERR;
                        end
                        OP_ADDC: acc_next = acc_reg + arg_reg;
                        OP_SUBC: acc_next = acc_reg - arg_reg;
                        OP_MULC:
                        begin
                            hold_next  = arg_reg;
                            state_next = S_MUL;
                        end
                        OP_DIVC:
                        begin
                            if (arg_reg == '0) st_next = ST_ERR;
                            else
                            begin
                                dreq.start    = 1'b1;
                                dreq.dividend = acc_reg;
                                dreq.divisor  = arg_reg;
                                state_next    = S_DIVW;
                            end
                        end
                        OP_JREL, OP_JZ, OP_JNZ:
                        begin
                            if (arg_reg == '0) st_next = ST_ERR;
                            else if (op_reg == OP_JREL
                                     || (op_reg == OP_JZ && acc_reg == '0)
                                     || (op_reg == OP_JNZ && acc_reg != '0))
                                step_next = arg_reg;
                        end
                        OP_NOOP: ;
                        OP_HALT: st_next = ST_HALT;
                        OP_OUT:
                        begin
                            emit_next = 1'b1;
                            val_next  = acc_reg;
                        end
                        OP_CHKMEM:
                        begin
                            if (!arg_neg && ({{(64-CW){1'b0}}, cnt_reg} < arg_reg))
                                st_next = ST_ERR;
                        end
                        OP_PRELOAD:
                        begin
                            step_next = '0;
                            if (cnt_reg < CW'(MEM_DEPTH))
                            begin
                                we       = 1'b1;
                                addr     = cnt_reg[AW-1:0];
                                wdata    = arg_reg;
                                cnt_next = cnt_reg + 1'b1;
                            end
                            else st_next = ST_ERR;
                        end
                        default: st_next = ST_UNK;
                    endcase
                    if (st_next == ST_ERR)
                    begin
                        step_next = '0;
                    end
                end
            end
            S_RDW:
            begin
                // memory word now on rdata
                state_next = S_DONE;
                case (op_reg)
                    OP_AT:   acc_next = rdata;
                    OP_ADDM: acc_next = acc_reg + rdata;
                    OP_SUBM: acc_next = acc_reg - rdata;
                    OP_MULM:
                    begin
                        hold_next  = rdata;
                        state_next = S_MUL;
                    end
                    default:
                    begin
                        if (rdata == '0)
                        begin
                            st_next   = ST_ERR;
                            step_next = '0;
                        end
                        else
                        begin
                            dreq.start    = 1'b1;
                            dreq.dividend = acc_reg;
                            dreq.divisor  = rdata;
                            state_next    = S_DIVW;
                        end
                    end
                endcase
            end
            S_SHIFT_RD:
            begin
                // insert moves words up from the top, erase moves them down
                if (op_reg == OP_INSERT)
                begin
                    if (ptr_reg == arg_reg[CW-1:0])
                    begin
                        we         = 1'b1;
                        addr       = ptr_reg[AW-1:0];
                        wdata      = acc_reg;
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        addr       = AW'(ptr_reg - 1'b1);
                        state_next = S_SHIFT_WR;
                    end
                end
                else
                begin
                    if (CW'(ptr_reg + 1'b1) >= cnt_reg)
                    begin
                        cnt_next   = cnt_reg - 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        addr       = AW'(ptr_reg + 1'b1);
                        state_next = S_SHIFT_WR;
                    end
                end
            end
            S_SHIFT_WR:
            begin
                we         = 1'b1;
                addr       = ptr_reg[AW-1:0];
                wdata      = rdata;
                ptr_next   = (op_reg == OP_INSERT) ? CW'(ptr_reg - 1'b1)
                                                   : CW'(ptr_reg + 1'b1);
                state_next = S_SHIFT_RD;
            end
            S_MUL:
            begin
                // low partial product and both cross products, modulo 2^64
                mul_next   = acc_reg[31:0] * hold_reg[31:0];
                acc_next   = {acc_reg[63:32] * hold_reg[31:0]
                              + acc_reg[31:0] * hold_reg[63:32], 32'd0};
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // second pass of the multiply: add the low partial product
                acc_next   = acc_reg + mul_reg;
                state_next = S_DONE;
            end
            S_DIVW:
            begin
                if (drsp.done)
                begin
                    acc_next   = drsp.quotient;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // move the result into the output register once it is free
                if (!ov_reg || !res_stall)
                begin
                    out_next.pc_step    = step_reg;
                    out_next.run_status = st_reg;
                    out_next.out_valid  = emit_reg;
                    out_next.out_value  = val_reg;
                    ov_next             = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            st_reg    <= ST_RUN;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            st_reg    <= st_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        arg_reg  <= arg_next;
        ptr_reg  <= ptr_next;
        hold_reg <= hold_next;
        mul_reg  <= mul_next;
        out_reg  <= out_next;
        step_reg <= step_next;
        emit_reg <= emit_next;
        val_reg  <= val_next;
    end

    `AVM_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CW'(MEM_DEPTH))
    `AVM_ASSERT_NEXT(a_stop_holds, clk, rst_n, st_reg != ST_RUN, $stable(st_reg))
    `AVM_ASSERT_IMP(a_no_take_busy, clk, rst_n, state_reg != S_IDLE, in_stall)
endmodule
`default_nettype wire

[tb/sv/accumulator_vm_execute_top_test.sv]
// self-checking testbench for the accumulator machine execute block
`default_nettype none

// instruction-level predictor and the queue of results it expects
class avm_scoreboard;
    logic [63:0] acc;
    logic [63:0] words [avm_pkg::MEM_DEPTH];
    int unsigned count;
    avm_pkg::run_t status;
    avm_pkg::out_t pending [$];
    int unsigned fails;

    function new();
        acc = '0;
        count = 0;
        status = avm_pkg::ST_RUN;
        fails = 0;
    endfunction

    function bit index_ok(logic [63:0] a);
        return !a[63] && a < count;
    endfunction

    // signed divide, truncating toward zero, min / -1 wraps
    function logic [63:0] sdiv(logic [63:0] a, logic [63:0] b);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] q;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        q = ma / mb;
        return (a[63] != b[63]) ? -q : q;
    endfunction

    // work out the result of one accepted instruction beat
    function void note_instr(avm_pkg::in_t it);
        avm_pkg::out_t e;
        logic [63:0] a;
        logic [63:0] m;
        logic [63:0] step;
        bit emit;
        bit bad;
        int i;
        a = it.argument;
        emit = 0;
        bad = 0;
        step = 0;
        if (status == avm_pkg::ST_RUN)
        begin
            step = 1;
            case (it.op)
                avm_pkg::OP_CLEAR: acc = '0;
                avm_pkg::OP_AT:
                    if (index_ok(a)) acc = words[a[7:0]]; else bad = 1;
                avm_pkg::OP_SET:
                    if (index_ok(a)) words[a[7:0]] = acc; else bad = 1;
                avm_pkg::OP_INSERT:
                    if (a[63] || a > count || count >= avm_pkg::MEM_DEPTH)
                        bad = 1;
                    else
                    begin
                        for (i = count; i > int'(a); i--) words[i] = words[i - 1];
                        words[a[7:0]] = acc;
                        count++;
                    end
                avm_pkg::OP_ERASE:
                    if (!index_ok(a)) bad = 1;
                    else
                    begin
                        for (i = int'(a); i + 1 < count; i++) words[i] = words[i + 1];
                        count--;
                    end
                avm_pkg::OP_ADDC: acc = acc + a;
                avm_pkg::OP_SUBC: acc = acc - a;
                avm_pkg::OP_MULC: acc = acc * a;
                avm_pkg::OP_DIVC:
                    if (a == 0) bad = 1; else acc = sdiv(acc, a);
                avm_pkg::OP_ADDM, avm_pkg::OP_SUBM, avm_pkg::OP_MULM, avm_pkg::OP_DIVM:
                    if (!index_ok(a)) bad = 1;
                    else
                    begin
                        m = words[a[7:0]];
                        case (it.op)
                            avm_pkg::OP_ADDM: acc = acc + m;
                            avm_pkg::OP_SUBM: acc = acc - m;
                            avm_pkg::OP_MULM: acc = acc * m;
                            default:
                                if (m == 0) bad = 1; else acc = sdiv(acc, m);
                        endcase
                    end
                avm_pkg::OP_JREL:
                    if (a == 0) bad = 1; else step = a;
                avm_pkg::OP_JZ:
                    if (a == 0) bad = 1; else step = (acc == 0) ? a : 64'd1;
                avm_pkg::OP_JNZ:
                    if (a == 0) bad = 1; else step = (acc != 0) ? a : 64'd1;
                avm_pkg::OP_NOOP: ;
                avm_pkg::OP_HALT: status = avm_pkg::ST_HALT;
                avm_pkg::OP_OUT: emit = 1;
                avm_pkg::OP_CHKMEM:
                    if (!a[63] && count < a) bad = 1;
                avm_pkg::OP_PRELOAD:
                    if (count >= avm_pkg::MEM_DEPTH) bad = 1;
                    else
                    begin
                        words[count] = a;
                        count++;
                        step = 0;
                    end
                default: status = avm_pkg::ST_UNK;
            endcase
            if (bad)
            begin
                status = avm_pkg::ST_ERR;
                step = 0;
            end
        end
        e.pc_step = step;
        e.run_status = status;
        e.out_valid = emit;
        e.out_value = emit ? acc : 64'd0;
        pending = {pending, e};
    endfunction

    // compare one result beat with the oldest expectation
    function void check_result(avm_pkg::out_t got);
        avm_pkg::out_t e;
        if (pending.size() == 0)
        begin
            $error("result beat with nothing expected");
            fails++;
            return;
        end
        e = pending.pop_front();
        if (got.pc_step !== e.pc_step)
        begin
            $error("pc_step expected %0d actual %0d", e.pc_step, got.pc_step);
            fails++;
        end
        if (got.run_status !== e.run_status)
        begin
            $error("run_status expected %0d actual %0d", e.run_status, got.run_status);
            fails++;
        end
        if (got.out_valid !== e.out_valid)
        begin
            $error("out_valid expected %0d actual %0d", e.out_valid, got.out_valid);
            fails++;
        end
        if (got.out_value !== e.out_value)
        begin
            $error("out_value expected %0d actual %0d", e.out_value, got.out_value);
            fails++;
        end
    endfunction
endclass

module accumulator_vm_execute_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import avm_pkg::*;

    localparam int RANDOM_ITEMS = 1400;
    localparam int CYCLE_LIMIT = 3000000;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    in_t in_data = '0;
    logic res_valid;
    logic res_stall = 0;
    out_t res_data;

    int send_idle = 25;
    int recv_idle = 88;
    bit hold_req = 0;
    int hold_left = 0;
    int unsigned cycles = 0;
    avm_scoreboard book = new();

    accumulator_vm_execute_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data)
    );

    always #2 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: check accepted beats, stall at random or for a long hold
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall) book.check_result(res_data);
        if (hold_req && hold_left == 0)
        begin
            hold_req = 0;
            hold_left = 600;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            res_stall <= 1'b1;
        end
        else
            res_stall <= ($urandom_range(99) < recv_idle);
    end

    // offer one instruction beat, with a random gap first
    task automatic send_instr(logic [4:0] op, logic [63:0] arg);
        in_t it;
        it.op = op;
        it.argument = arg;
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle);
        end
        in_data <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        book.note_instr(it);
    endtask

    function automatic logic [63:0] rand64();
        case ($urandom_range(3))
            0: return {$urandom, $urandom};
            1: return 64'($signed($urandom_range(20)) - 10);
            2: return {1'b1, 63'($urandom)} ^ {$urandom, $urandom};
            default: return 64'($urandom_range(1000));
        endcase
    endfunction

    // one well-formed instruction that keeps the machine running
    task automatic send_random();
        int r;
        int unsigned n;
        logic [63:0] v;
        logic [4:0] op;
        r = $urandom_range(99);
        n = book.count;
        v = rand64();
        if (n == 0 || r < 12)
        begin
            if (n < 40 || $urandom_range(1) == 0)
            begin
                if ($urandom_range(1))
                    send_instr(OP_PRELOAD, v);
                else
                    send_instr(OP_INSERT, 64'($urandom_range(n)));
            end
            else
                send_instr(OP_ERASE, 64'($urandom_range(n - 1)));
        end
        else if (r < 20)
            send_instr(n > 24 ? OP_ERASE : OP_INSERT,
                64'($urandom_range(n > 24 ? n - 1 : n)));
        else if (r < 45)
        begin
            op = 5'(OP_ADDC + $urandom_range(2));
            send_instr(op, v);
        end
        else if (r < 50)
            send_instr(OP_DIVC, v == 0 ? 64'd3 : v);
        else if (r < 68)
        begin
            v = 64'($urandom_range(n - 1));
            op = 5'(OP_AT + $urandom_range(1));
            if ($urandom_range(1)) op = 5'(OP_ADDM + $urandom_range(3));
            if (op == OP_DIVM && book.words[v[7:0]] == 0) op = OP_SUBM;
            send_instr(op, v);
        end
        else if (r < 80)
        begin
            op = 5'(OP_JREL + $urandom_range(2));
            send_instr(op, v == 0 ? -64'd1 : v);
        end
        else if (r < 86)
            send_instr(OP_CHKMEM, $urandom_range(1) ? 64'($urandom_range(n)) : (v | 64'h1 << 63));
        else
        begin
            case ($urandom_range(2))
                0: op = OP_OUT;
                1: op = OP_NOOP;
                default: op = OP_CLEAR;
            endcase
            send_instr(op, v);
        end
    endtask

    localparam logic [63:0] MAXV = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] MINV = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;

    initial
    begin
        int k;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every legal op but halt, min divided by minus one
        send_instr(OP_PRELOAD, MAXV);
        send_instr(OP_PRELOAD, MINV);
        send_instr(OP_PRELOAD, 64'd0);
        send_instr(OP_PRELOAD, ONES);
        send_instr(OP_AT, 64'd1);
        send_instr(OP_OUT, 64'd0);
        send_instr(OP_DIVM, 64'd3);
        send_instr(OP_OUT, ONES);
        send_instr(OP_CLEAR, 64'd0);
        send_instr(OP_JZ, MAXV);
        send_instr(OP_ADDC, MAXV);
        send_instr(OP_SUBC, ONES);
        send_instr(OP_MULC, ONES);
        send_instr(OP_DIVC, ONES);
        send_instr(OP_INSERT, 64'd4);
        send_instr(OP_INSERT, 64'd0);
        send_instr(OP_SET, 64'd2);
        send_instr(OP_ERASE, 64'd0);
        send_instr(OP_ADDM, 64'd0);
        send_instr(OP_SUBM, 64'd2);
        send_instr(OP_MULM, 64'd4);
        send_instr(OP_JREL, MINV);
        send_instr(OP_JNZ, -64'd5);
        send_instr(OP_CHKMEM, 64'd5);
        send_instr(OP_CHKMEM, MINV);
        send_instr(OP_NOOP, ONES);

        // random, three idling phases, long result hold in the last
        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == RANDOM_ITEMS / 3)
            begin
                send_idle = 88;
                recv_idle = 25;
            end
            if (k == 2 * RANDOM_ITEMS / 3)
            begin
                send_idle = 0;
                recv_idle = 0;
                hold_req = 1;
            end
            send_random();
        end

        // a stop case unless op 21 is drawn, then beats a stopped machine must ignore
        case ($urandom_range(6))
            0: send_instr(OP_HALT, 64'd0);
            1: send_instr(5'($urandom_range(31, 20)), rand64());
            2: send_instr(OP_JREL, 64'd0);
            3: send_instr(OP_DIVC, 64'd0);
            4: send_instr(OP_AT, 64'(book.count));
            5: send_instr(OP_CHKMEM, 64'(book.count + 1));
            default: send_instr(OP_ERASE, ONES);
        endcase
        for (k = 0; k < 6; k++) send_random();
        send_instr(OP_PRELOAD, ONES);
        in_valid <= 1'b0;

        while (book.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (book.fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
+incdir+sv
sv/avm_pkg.sv
sv/avm_ram.sv
sv/avm_div.sv
sv/accumulator_vm_execute_top.sv
tb/sv/accumulator_vm_execute_top_test.sv
